// File: rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants, types and byte classes for the punctuation and
// identifier tokenizer.
// ----------------------------------------------------------------------------
package pit_pkg;

   // Default widths of the offset and length fields
   localparam int OFFSET_BITS_DEF = 24;
   localparam int LENGTH_BITS_DEF = 16;
   // Token queue depth between scanner and output stage
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int KIND_BITS = 4;

   // Token kinds
   localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_COLON    = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_ARROW    = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_MINUS    = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_IDENT    = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_END      = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN  = 4'd11;

   // Byte values
   localparam logic [7:0] CHAR_HASH     = 8'h23;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_GT       = 8'h3E;
   localparam logic [7:0] CHAR_EOF      = 8'hFF;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_LPAREN   = 8'h28;
   localparam logic [7:0] CHAR_RPAREN   = 8'h29;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;

   // Scanner mode
   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COMMENT = 2'd1,
      MODE_MINUS   = 2'd2,
      MODE_IDENT   = 2'd3
   } pit_mode_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } pit_queue_status_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic is_ident_start(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))
             || (b == 8'h5F);
   endfunction

   function automatic logic is_ident_char(input logic [7:0] b);
      return is_ident_start(b) || ((b >= 8'h30) && (b <= 8'h39));
   endfunction

   // One-byte punctuation: returns {hit, kind}
   function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] b);
      logic [KIND_BITS:0] r;
      case (b)
         CHAR_LPAREN:   r = {1'b1, KIND_LPAREN};
         CHAR_RPAREN:   r = {1'b1, KIND_RPAREN};
         CHAR_LBRACKET: r = {1'b1, KIND_LBRACKET};
         CHAR_RBRACKET: r = {1'b1, KIND_RBRACKET};
         CHAR_LBRACE:   r = {1'b1, KIND_LBRACE};
         CHAR_RBRACE:   r = {1'b1, KIND_RBRACE};
         CHAR_COLON:    r = {1'b1, KIND_COLON};
         default:       r = {1'b0, KIND_UNKNOWN};
      endcase
      return r;
   endfunction

endpackage

// File: rtl/punctuation_ident_tokenizer.sv
// ----------------------------------------------------------------------------
// punctuation_ident_tokenizer
// Streaming scanner that cuts source bytes into bracket, colon, arrow,
// minus, identifier, end and error tokens.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per source byte (req_byte_in), or an end mark
//   (req_end_mark high, byte ignored). A word is taken at a clock edge with
//   req_valid high and req_stall low. Whitespace and '#' comments produce
//   nothing; other bytes give zero, one or two tokens.
//   rsp channel: one token per word (kind, start offset, length, sticky
//   failed flag, last = final token caused by that input word).
// Throughput: one input word per cycle while req_stall is low, one token per
//   cycle out while rsp_stall is low. The output stage is the limit: a word
//   giving two tokens holds it for both, so the token queue (QUEUE_DEPTH
//   entries) absorbs bursts and req_stall rises only when it is full.
// Path: a taken word is queued, then its token is loaded onto rsp; the
//   second token of a pair is loaded once the first is taken.
// Reset: synchronous, clears the scan mode, offsets, failed flag and queue;
//   the block takes words as soon as reset is released.
// Receiver stall: rsp word holds; the queue keeps taking words until full.
// ----------------------------------------------------------------------------
module punctuation_ident_tokenizer #(
   parameter int OFFSET_BITS = pit_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = pit_pkg::LENGTH_BITS_DEF,
   parameter int QUEUE_DEPTH = pit_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Source byte channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_byte_in,
   input  logic                          req_end_mark,
   // Token channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pit_pkg::KIND_BITS-1:0] rsp_kind,
   output logic [OFFSET_BITS-1:0]        rsp_start_offset,
   output logic [LENGTH_BITS-1:0]        rsp_length,
   output logic                          rsp_failed,
   output logic                          rsp_last
);

   localparam int TOK_BITS   = pit_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS;
   localparam int ENTRY_BITS = 2 + 2 * TOK_BITS;

   pit_pkg::pit_queue_status_type queue_status;
   logic                  accept;
   logic                  push;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop;
   logic [ENTRY_BITS-1:0] head_data;
   logic                  scan_failed;

   // Take a word whenever the queue has room for its token pair
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   pit_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .TOK_BITS    (TOK_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_byte_in),
      .end_mark  (req_end_mark),
      .push      (push),
      .push_data (push_data),
      .failed    (scan_failed)
   );

   // Each entry carries one or two tokens of the same input word
   pit_fifo #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   pit_back #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .TOK_BITS    (TOK_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (queue_status),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_length       (rsp_length),
      .rsp_failed       (rsp_failed),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTH
   // The second token of a pair follows the first with no gap
   a_pair_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("token pair broken by an idle cycle");

   // An end token always closes the tokens of its word
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == pit_pkg::KIND_END) |-> rsp_last)
      else $error("end token not marked last");

   // The failed flag never clears outside reset
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      scan_failed |=> scan_failed)
      else $error("failed flag dropped");

   // Nothing is popped from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("pop from empty token queue");
`endif

endmodule

// File: rtl/pit_fifo.sv
// ----------------------------------------------------------------------------
// pit_fifo
// Short register queue of scanned token pairs between scanner and output.
// ----------------------------------------------------------------------------
module pit_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pit_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              head_data,
   output pit_pkg::pit_queue_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/pit_front.sv
// ----------------------------------------------------------------------------
// pit_front
// Byte scanner: tracks the scan mode and offsets, builds up to two tokens
// per accepted word and pushes them as one queue entry.
// ----------------------------------------------------------------------------
module pit_front #(
   parameter int OFFSET_BITS = pit_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = pit_pkg::LENGTH_BITS_DEF,
   parameter int TOK_BITS    = pit_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS,
   parameter int ENTRY_BITS  = 2 + 2 * TOK_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            byte_in,
   input  logic                  end_mark,
   output logic                  push,
   output logic [ENTRY_BITS-1:0] push_data,
   output logic                  failed
);

   localparam int WIDE_BITS = (OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS;
   localparam logic [WIDE_BITS-1:0] LEN_CAP = WIDE_BITS'({LENGTH_BITS{1'b1}});

   pit_pkg::pit_mode_type mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic                   failed_ff, failed_in;

   logic [OFFSET_BITS-1:0] span;
   logic [WIDE_BITS-1:0]   span_wide;
   logic [LENGTH_BITS-1:0] ident_len;

   logic                              do_flush;
   logic [pit_pkg::KIND_BITS-1:0]     flush_kind;
   logic [LENGTH_BITS-1:0]            flush_len;
   logic                              sec_valid;
   logic [pit_pkg::KIND_BITS-1:0]     sec_kind;
   logic [OFFSET_BITS-1:0]            sec_start;
   logic [LENGTH_BITS-1:0]            sec_len;
   logic [pit_pkg::KIND_BITS:0]       punct;
   logic [TOK_BITS-1:0]               tok_a, tok_b;

   assign span      = pos_ff - start_ff;
   assign span_wide = WIDE_BITS'(span);
   assign ident_len = (span_wide > LEN_CAP) ? '1 : LENGTH_BITS'(span_wide);
   assign punct     = pit_pkg::punct_kind(byte_in);

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      failed_in = failed_ff;
      do_flush  = 1'b0;
      sec_valid = 1'b0;
      sec_kind  = pit_pkg::KIND_END;
      sec_start = pos_ff;
      sec_len   = '0;

      if (end_mark) begin
         do_flush  = 1'b1;
         sec_valid = 1'b1;
         mode_in   = pit_pkg::MODE_IDLE;
      end else begin
         if (byte_in == pit_pkg::CHAR_EOF) begin
            do_flush  = 1'b1;
            sec_valid = 1'b1;
            sec_len   = LENGTH_BITS'(1);
            mode_in   = pit_pkg::MODE_IDLE;
         end else if (mode_ff == pit_pkg::MODE_COMMENT) begin
            if (byte_in == pit_pkg::CHAR_LF) begin
               mode_in = pit_pkg::MODE_IDLE;
            end
         end else if (mode_ff == pit_pkg::MODE_MINUS && byte_in == pit_pkg::CHAR_GT) begin
            sec_valid = 1'b1;
            sec_kind  = pit_pkg::KIND_ARROW;
            sec_start = start_ff;
            sec_len   = LENGTH_BITS'(2);
            mode_in   = pit_pkg::MODE_IDLE;
         end else if (mode_ff == pit_pkg::MODE_IDENT && pit_pkg::is_ident_char(byte_in)) begin
            mode_in = pit_pkg::MODE_IDENT;
         end else begin
            // Flush any pending token first, then scan the byte from idle
            do_flush = 1'b1;
            mode_in  = pit_pkg::MODE_IDLE;
            if (pit_pkg::is_space(byte_in)) begin
               mode_in = pit_pkg::MODE_IDLE;
            end else if (byte_in == pit_pkg::CHAR_HASH) begin
               mode_in = pit_pkg::MODE_COMMENT;
            end else if (punct[pit_pkg::KIND_BITS]) begin
               sec_valid = 1'b1;
               sec_kind  = punct[pit_pkg::KIND_BITS-1:0];
               sec_len   = LENGTH_BITS'(1);
            end else if (byte_in == pit_pkg::CHAR_MINUS) begin
               start_in = pos_ff;
               mode_in  = pit_pkg::MODE_MINUS;
            end else if (pit_pkg::is_ident_start(byte_in)) begin
               start_in = pos_ff;
               mode_in  = pit_pkg::MODE_IDENT;
            end else begin
               sec_valid = 1'b1;
               sec_kind  = pit_pkg::KIND_UNKNOWN;
               sec_len   = LENGTH_BITS'(1);
               failed_in = 1'b1;
            end
         end
         if (pos_ff != '1) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      // Flush only emits when a minus or identifier is pending
      if (mode_ff != pit_pkg::MODE_MINUS && mode_ff != pit_pkg::MODE_IDENT) begin
         do_flush = 1'b0;
      end
   end

   assign flush_kind = (mode_ff == pit_pkg::MODE_MINUS) ? pit_pkg::KIND_MINUS
                                                        : pit_pkg::KIND_IDENT;
   assign flush_len  = (mode_ff == pit_pkg::MODE_MINUS) ? LENGTH_BITS'(1) : ident_len;

   assign tok_b     = {sec_kind, sec_start, sec_len};
   assign tok_a     = do_flush ? {flush_kind, start_ff, flush_len} : tok_b;
   assign push      = accept && (do_flush || sec_valid);
   assign push_data = {do_flush && sec_valid, failed_in, tok_a, tok_b};
   assign failed    = failed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pit_pkg::MODE_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         start_ff  <= '0;
         failed_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         failed_ff <= failed_in;
      end
   end

endmodule

// File: rtl/pit_back.sv
// ----------------------------------------------------------------------------
// pit_back
// Output stage: pops queue entries, presents their tokens one word per cycle
// unless stalled, holding an entry's second token until the first is taken.
// ----------------------------------------------------------------------------
module pit_back #(
   parameter int OFFSET_BITS = pit_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = pit_pkg::LENGTH_BITS_DEF,
   parameter int TOK_BITS    = pit_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS,
   parameter int ENTRY_BITS  = 2 + 2 * TOK_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pit_pkg::pit_queue_status_type status,
   input  logic [ENTRY_BITS-1:0]         head_data,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pit_pkg::KIND_BITS-1:0] rsp_kind,
   output logic [OFFSET_BITS-1:0]        rsp_start_offset,
   output logic [LENGTH_BITS-1:0]        rsp_length,
   output logic                          rsp_failed,
   output logic                          rsp_last
);

   logic                valid_ff, valid_in;
   logic                last_ff, last_in;
   logic                failed_ff, failed_in;
   logic [TOK_BITS-1:0] out_tok_ff, out_tok_in;
   logic                sec_valid_ff, sec_valid_in;
   logic [TOK_BITS-1:0] sec_tok_ff, sec_tok_in;

   logic                out_free;
   logic                head_two;
   logic                head_failed;
   logic [TOK_BITS-1:0] head_tok_a, head_tok_b;

   assign {head_two, head_failed, head_tok_a, head_tok_b} = head_data;
   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = out_free && !sec_valid_ff && !status.empty;

   always_comb begin
      valid_in     = valid_ff;
      last_in      = last_ff;
      failed_in    = failed_ff;
      out_tok_in   = out_tok_ff;
      sec_valid_in = sec_valid_ff;
      sec_tok_in   = sec_tok_ff;
      if (out_free) begin
         if (sec_valid_ff) begin
            // Advance to the held second token
            valid_in     = 1'b1;
            last_in      = 1'b1;
            out_tok_in   = sec_tok_ff;
            sec_valid_in = 1'b0;
         end else if (!status.empty) begin
            valid_in     = 1'b1;
            last_in      = !head_two;
            failed_in    = head_failed;
            out_tok_in   = head_tok_a;
            sec_valid_in = head_two;
            sec_tok_in   = head_tok_b;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      failed_ff  <= failed_in;
      out_tok_ff <= out_tok_in;
      sec_tok_ff <= sec_tok_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_last  = last_ff;
   assign rsp_failed = failed_ff;
   assign {rsp_kind, rsp_start_offset, rsp_length} = out_tok_ff;

endmodule

// File: tb/sv/punctuation_ident_tokenizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// punctuation_ident_tokenizer_test
// Self-checking bench for the source tokenizer. It runs a short directed
// table of source words, then a random stretch of token text mixed with
// noise. Tokens are checked against a bench scanner model, typed rows against
// their own tokens. The sender works in bursts, the receiver stalls at random.
// ----------------------------------------------------------------------------
module punctuation_ident_tokenizer_test;

   localparam int OFF_W = pit_pkg::OFFSET_BITS_DEF;
   localparam int LEN_W = pit_pkg::LENGTH_BITS_DEF;
   localparam int KIND_W = pit_pkg::KIND_BITS;
   localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_WORDS = 1400;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_LIMIT = 10;
   localparam int RUN_LIMIT_NS = 10_000_000;

   // Source bytes the package does not name
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_VT         = 8'h0B;
   localparam logic [7:0] CHAR_FF         = 8'h0C;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_HIGH       = 8'h80;

   localparam logic [7:0] BRACKET_BYTES [0:6] = '{pit_pkg::CHAR_LPAREN,
      pit_pkg::CHAR_RPAREN, pit_pkg::CHAR_LBRACKET, pit_pkg::CHAR_RBRACKET,
      pit_pkg::CHAR_LBRACE, pit_pkg::CHAR_RBRACE, pit_pkg::CHAR_COLON};
   localparam logic [7:0] BLANK_BYTES [0:5] = '{CHAR_SPACE, CHAR_TAB,
      pit_pkg::CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};

   // Receiver stall styles
   typedef enum logic [1:0] {
      STALL_NONE  = 2'd0,
      STALL_LIGHT = 2'd1,
      STALL_HEAVY = 2'd2,
      STALL_HOLD  = 2'd3
   } stall_style_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OFF_W-1:0]  start;
      logic [LEN_W-1:0]  length;
      logic              failed;
      logic              last;
   } token_type;

   // One source word; typed rows carry their token written out by hand
   typedef struct packed {
      logic [7:0] src;
      logic       end_mark;
      logic       typed;
      logic [1:0] typed_count;
      token_type  typed_token;
   } src_word_type;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   logic [7:0]        req_byte_in  = 8'h00;
   logic              req_end_mark = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [OFF_W-1:0]  rsp_start_offset;
   logic [LEN_W-1:0]  rsp_length;
   logic              rsp_failed;
   logic              rsp_last;

   // Scanner model state
   pit_pkg::pit_mode_type scan_state  = pit_pkg::MODE_IDLE;
   logic [OFF_W-1:0]      next_offset = '0;
   logic [OFF_W-1:0]      pend_start  = '0;
   logic                  saw_unknown = 1'b0;
   token_type             new_tokens[$];
   token_type             token_fifo[$];

   // Sender and receiver pacing
   int                    burst_left  = 0;
   stall_style_type       stall_style = STALL_NONE;
   int                    stall_span  = 0;

   // Run statistics
   int                    mismatches  = 0;
   int                    words_sent  = 0;
   int                    end_marks   = 0;
   int                    tokens_seen = 0;
   logic [15:0]           kinds_seen  = '0;

   punctuation_ident_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .req_end_mark     (req_end_mark),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_length       (rsp_length),
      .rsp_failed       (rsp_failed),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Byte classes
   // -------------------------------------------------------------------------
   function automatic logic blank_byte(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic word_head(input logic [7:0] b);
      return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z))
             || ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z))
             || (b == CHAR_UNDERSCORE);
   endfunction

   function automatic logic word_tail(input logic [7:0] b);
      return word_head(b) || ((b >= CHAR_DIGIT_0) && (b <= CHAR_DIGIT_9));
   endfunction

   // Brackets and the colon are one-byte tokens; report hit and kind
   function automatic logic bracket_kind(input logic [7:0] b,
                                         output logic [KIND_W-1:0] kind);
      logic hit;
      hit = 1'b1;
      case (b)
         pit_pkg::CHAR_LPAREN:   kind = pit_pkg::KIND_LPAREN;
         pit_pkg::CHAR_RPAREN:   kind = pit_pkg::KIND_RPAREN;
         pit_pkg::CHAR_LBRACKET: kind = pit_pkg::KIND_LBRACKET;
         pit_pkg::CHAR_RBRACKET: kind = pit_pkg::KIND_RBRACKET;
         pit_pkg::CHAR_LBRACE:   kind = pit_pkg::KIND_LBRACE;
         pit_pkg::CHAR_RBRACE:   kind = pit_pkg::KIND_RBRACE;
         pit_pkg::CHAR_COLON:    kind = pit_pkg::KIND_COLON;
         default: begin
            kind = pit_pkg::KIND_UNKNOWN;
            hit  = 1'b0;
         end
      endcase
      return hit;
   endfunction

   // Random identifier byte: letters and underscore, plus digits past the head
   function automatic logic [7:0] word_byte(input logic tail);
      int r;
      r = $urandom_range(0, tail ? 62 : 52);
      if (r < 26) return CHAR_UPPER_A + 8'(r);
      if (r < 52) return CHAR_LOWER_A + 8'(r - 26);
      if (r == 52) return CHAR_UNDERSCORE;
      return CHAR_DIGIT_0 + 8'(r - 53);
   endfunction

   // -------------------------------------------------------------------------
   // Scanner model
   // -------------------------------------------------------------------------
   function automatic void add_token(input logic [KIND_W-1:0] kind,
                                     input logic [OFF_W-1:0] start,
                                     input logic [OFF_W-1:0] span);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      // saturate the length field
      t.length = (span > OFF_W'(LEN_MAX)) ? LEN_MAX : span[LEN_W-1:0];
      t.failed = 1'b0;
      t.last   = 1'b0;
      new_tokens.push_back(t);
   endfunction

   // Emit a waiting minus or identifier and drop back to idle
   function automatic void flush_pending();
      if (scan_state == pit_pkg::MODE_MINUS)
         add_token(pit_pkg::KIND_MINUS, pend_start, OFF_W'(1));
      else if (scan_state == pit_pkg::MODE_IDENT)
         add_token(pit_pkg::KIND_IDENT, pend_start, next_offset - pend_start);
      scan_state = pit_pkg::MODE_IDLE;
   endfunction

   // Advance the model by one source word; tokens land in new_tokens
   function automatic void scan_word(input logic [7:0] b, input logic e);
      logic [KIND_W-1:0] kind;
      new_tokens.delete();
      if (e) begin
         // end mark: no byte, the offset stays put
         flush_pending();
         add_token(pit_pkg::KIND_END, next_offset, OFF_W'(0));
      end else begin
         if (b == pit_pkg::CHAR_EOF) begin
            // 0xFF is a real byte that ends the text, even inside a comment
            flush_pending();
            add_token(pit_pkg::KIND_END, next_offset, OFF_W'(1));
         end else if (scan_state == pit_pkg::MODE_COMMENT) begin
            if (b == pit_pkg::CHAR_LF)
               scan_state = pit_pkg::MODE_IDLE;
         end else if ((scan_state == pit_pkg::MODE_MINUS) && (b == pit_pkg::CHAR_GT)) begin
            add_token(pit_pkg::KIND_ARROW, pend_start, OFF_W'(2));
            scan_state = pit_pkg::MODE_IDLE;
         end else if (!((scan_state == pit_pkg::MODE_IDENT) && word_tail(b))) begin
            // the byte cannot extend what is waiting: flush, then start fresh
            flush_pending();
            if (b == pit_pkg::CHAR_HASH) begin
               scan_state = pit_pkg::MODE_COMMENT;
            end else if (bracket_kind(b, kind)) begin
               add_token(kind, next_offset, OFF_W'(1));
            end else if (b == pit_pkg::CHAR_MINUS) begin
               pend_start = next_offset;
               scan_state = pit_pkg::MODE_MINUS;
            end else if (word_head(b)) begin
               pend_start = next_offset;
               scan_state = pit_pkg::MODE_IDENT;
            end else if (!blank_byte(b)) begin
               add_token(pit_pkg::KIND_UNKNOWN, next_offset, OFF_W'(1));
               saw_unknown = 1'b1;
            end
         end
         if (next_offset != OFF_MAX)
            next_offset++;
      end
      foreach (new_tokens[i]) begin
         new_tokens[i].failed = saw_unknown;
         new_tokens[i].last   = (i == new_tokens.size() - 1);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Directed table rows
   // -------------------------------------------------------------------------
   function automatic src_word_type scan_row(input logic [7:0] b, input logic e);
      src_word_type r;
      r          = '0;
      r.src      = b;
      r.end_mark = e;
      return r;
   endfunction

   // Row whose single token, or lack of one, is written out
   function automatic src_word_type fixed_row(input logic [7:0] b, input logic e,
                                              input logic [1:0] n,
                                              input logic [KIND_W-1:0] kind,
                                              input int start, input int span,
                                              input logic failed);
      src_word_type r;
      r                    = scan_row(b, e);
      r.typed              = 1'b1;
      r.typed_count        = n;
      r.typed_token.kind   = kind;
      r.typed_token.start  = OFF_W'(start);
      r.typed_token.length = LEN_W'(span);
      r.typed_token.failed = failed;
      r.typed_token.last   = 1'b1;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Sender: present one word and hold it until the block takes it
   // -------------------------------------------------------------------------
   task automatic drive_word(input logic [7:0] b, input logic e, input logic paced);
      int gap;
      gap = 0;
      if (paced) begin
         // start a new burst after a gap; some bursts follow with no gap
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_valid    <= 1'b0;
         req_byte_in  <= 8'($urandom);
         req_end_mark <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_byte_in  <= b;
      req_end_mark <= e;
      // stall is sampled as it stood at the edge
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (e)
         end_marks++;
   endtask

   task automatic accept_word(input logic [7:0] b, input logic e, input logic paced);
      drive_word(b, e, paced);
      scan_word(b, e);
      foreach (new_tokens[i])
         token_fifo.push_back(new_tokens[i]);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: check each token taken, then pick the next stall value
   // -------------------------------------------------------------------------
   task automatic check_token();
      token_type got;
      token_type want;
      got.kind   = rsp_kind;
      got.start  = rsp_start_offset;
      got.length = rsp_length;
      got.failed = rsp_failed;
      got.last   = rsp_last;
      tokens_seen++;
      kinds_seen[rsp_kind] = 1'b1;
      if (token_fifo.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: token with nothing expected: kind %0d start %0d length %0d",
                     $time, got.kind, got.start, got.length);
      end else begin
         want = token_fifo.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: token %0d mismatch", $time, tokens_seen);
               $display("   expected kind %0d start %0d length %0d failed %0b last %0b",
                        want.kind, want.start, want.length, want.failed, want.last);
               $display("   actual   kind %0d start %0d length %0d failed %0b last %0b",
                        got.kind, got.start, got.length, got.failed, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_token();
         // hold each stall style for a random span of cycles
         if (stall_span == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            stall_span  = $urandom_range(1, 40);
         end else begin
            stall_span--;
         end
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= 1'b1;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin : stimulus
      src_word_type      dir_rows[$];
      src_word_type      rand_words[$];
      int                pick;
      int                reps;
      logic [7:0]        b;
      logic [KIND_W-1:0] kind_unused;

      // Directed table. Offsets count source bytes; end marks take none.
      // End mark straight out of reset: end token at offset zero, length zero
      dir_rows.push_back(fixed_row(CHAR_NUL, 1'b1, 2'd1, pit_pkg::KIND_END,
                                   0, 0, 1'b0));
      // Every bracket and the colon, one byte each
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_LPAREN, 1'b0, 2'd1,
                                   pit_pkg::KIND_LPAREN, 0, 1, 1'b0));
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_RPAREN, 1'b0, 2'd1,
                                   pit_pkg::KIND_RPAREN, 1, 1, 1'b0));
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_LBRACKET, 1'b0, 2'd1,
                                   pit_pkg::KIND_LBRACKET, 2, 1, 1'b0));
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_RBRACKET, 1'b0, 2'd1,
                                   pit_pkg::KIND_RBRACKET, 3, 1, 1'b0));
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_LBRACE, 1'b0, 2'd1,
                                   pit_pkg::KIND_LBRACE, 4, 1, 1'b0));
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_RBRACE, 1'b0, 2'd1,
                                   pit_pkg::KIND_RBRACE, 5, 1, 1'b0));
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_COLON, 1'b0, 2'd1,
                                   pit_pkg::KIND_COLON, 6, 1, 1'b0));
      // Whitespace gives nothing
      dir_rows.push_back(fixed_row(CHAR_SPACE, 1'b0, 2'd0, pit_pkg::KIND_END,
                                   0, 0, 1'b0));
      // Arrow, then a minus cut off by a second minus
      dir_rows.push_back(scan_row(pit_pkg::CHAR_MINUS, 1'b0));
      dir_rows.push_back(scan_row(pit_pkg::CHAR_GT, 1'b0));
      dir_rows.push_back(scan_row(pit_pkg::CHAR_MINUS, 1'b0));
      dir_rows.push_back(scan_row(pit_pkg::CHAR_MINUS, 1'b0));
      // Minus flushed by an identifier head; identifier flushed by a colon
      dir_rows.push_back(scan_row(CHAR_LOWER_A, 1'b0));
      dir_rows.push_back(scan_row(CHAR_UPPER_Z, 1'b0));
      dir_rows.push_back(scan_row(CHAR_DIGIT_9, 1'b0));
      dir_rows.push_back(scan_row(CHAR_UNDERSCORE, 1'b0));
      dir_rows.push_back(scan_row(pit_pkg::CHAR_COLON, 1'b0));
      // 0xFF ends a comment and gives an end token of length one
      dir_rows.push_back(scan_row(pit_pkg::CHAR_HASH, 1'b0));
      dir_rows.push_back(fixed_row(pit_pkg::CHAR_EOF, 1'b0, 2'd1, pit_pkg::KIND_END,
                                   18, 1, 1'b0));
      // Comment closed by a newline, then an identifier flushed by an end mark
      // that carries 0xFF as its ignored byte
      dir_rows.push_back(scan_row(pit_pkg::CHAR_HASH, 1'b0));
      dir_rows.push_back(scan_row(CHAR_LOWER_Z, 1'b0));
      dir_rows.push_back(scan_row(pit_pkg::CHAR_LF, 1'b0));
      dir_rows.push_back(scan_row(CHAR_UNDERSCORE, 1'b0));
      dir_rows.push_back(scan_row(pit_pkg::CHAR_EOF, 1'b1));
      // First unknown byte raises the failed flag
      dir_rows.push_back(fixed_row(CHAR_NUL, 1'b0, 2'd1, pit_pkg::KIND_UNKNOWN,
                                   23, 1, 1'b1));
      dir_rows.push_back(scan_row(CHAR_HIGH, 1'b0));
      // Minus flushed by 0xFF: two tokens from one word
      dir_rows.push_back(scan_row(pit_pkg::CHAR_MINUS, 1'b0));
      dir_rows.push_back(scan_row(pit_pkg::CHAR_EOF, 1'b0));

      // Random token text: mostly well-formed pieces, some noise
      while (rand_words.size() < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            rand_words.push_back(scan_row(word_byte(1'b0), 1'b0));
            reps = $urandom_range(0, 10);
            repeat (reps) rand_words.push_back(scan_row(word_byte(1'b1), 1'b0));
         end else if (pick < 45) begin
            rand_words.push_back(scan_row(BRACKET_BYTES[$urandom_range(0, 6)], 1'b0));
         end else if (pick < 53) begin
            rand_words.push_back(scan_row(pit_pkg::CHAR_MINUS, 1'b0));
            rand_words.push_back(scan_row(pit_pkg::CHAR_GT, 1'b0));
         end else if (pick < 59) begin
            rand_words.push_back(scan_row(pit_pkg::CHAR_MINUS, 1'b0));
         end else if (pick < 71) begin
            reps = $urandom_range(1, 3);
            repeat (reps)
               rand_words.push_back(scan_row(BLANK_BYTES[$urandom_range(0, 5)], 1'b0));
         end else if (pick < 77) begin
            // comment with a random body, closed by a newline
            rand_words.push_back(scan_row(pit_pkg::CHAR_HASH, 1'b0));
            reps = $urandom_range(0, 8);
            repeat (reps) begin
               b = 8'($urandom_range(0, 254));
               if (b == pit_pkg::CHAR_LF)
                  b = CHAR_TAB;
               rand_words.push_back(scan_row(b, 1'b0));
            end
            rand_words.push_back(scan_row(pit_pkg::CHAR_LF, 1'b0));
         end else if (pick < 81) begin
            rand_words.push_back(scan_row(pit_pkg::CHAR_EOF, 1'b0));
         end else if (pick < 85) begin
            rand_words.push_back(scan_row(8'($urandom), 1'b1));
         end else if (pick < 93) begin
            // a byte no class claims
            do begin
               b = 8'($urandom);
            end while (blank_byte(b) || word_head(b) || bracket_kind(b, kind_unused)
                       || (b == pit_pkg::CHAR_HASH) || (b == pit_pkg::CHAR_MINUS)
                       || (b == pit_pkg::CHAR_EOF));
            rand_words.push_back(scan_row(b, 1'b0));
         end else begin
            rand_words.push_back(scan_row(8'($urandom), 1'b0));
         end
      end

      // Hold reset, then release it at an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; typed rows replace the model's tokens with their own
      foreach (dir_rows[i]) begin
         drive_word(dir_rows[i].src, dir_rows[i].end_mark, 1'b1);
         scan_word(dir_rows[i].src, dir_rows[i].end_mark);
         if (!dir_rows[i].typed) begin
            foreach (new_tokens[k])
               token_fifo.push_back(new_tokens[k]);
         end else if (dir_rows[i].typed_count != 2'd0) begin
            token_fifo.push_back(dir_rows[i].typed_token);
         end
      end

      foreach (rand_words[i])
         accept_word(rand_words[i].src, rand_words[i].end_mark, 1'b1);
      req_valid <= 1'b0;

      // Drain, then give stray tokens a window to show up
      while (token_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d source words (%0d end marks) and %0d tokens of %0d kinds,",
               words_sent, end_marks, tokens_seen, $countones(kinds_seen));
      $display("sent in random bursts against a receiver stalling in random runs.");
      if (mismatches == 0)
         $display("punctuation_ident_tokenizer_test: PASS");
      else
         $display("punctuation_ident_tokenizer_test: FAIL");
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("punctuation_ident_tokenizer_test: FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/pit_pkg.sv
rtl/pit_fifo.sv
rtl/pit_front.sv
rtl/pit_back.sv
rtl/punctuation_ident_tokenizer.sv
tb/sv/punctuation_ident_tokenizer_test.sv
